// ----- sv/hbd_pkg.sv -----
// shared types, constants and codes for the hdlc bit destuffing decoder
// no dependencies; imported by every module of the block
package hbd_pkg;

    // largest frame in bytes that the position counter can describe
    localparam int unsigned FRAME_LIMIT = 4095;
    // last output bit position, the counter saturates here
    localparam int unsigned POS_MAX     = FRAME_LIMIT * 8 + 7;
    localparam int unsigned POS_W       = $clog2(POS_MAX + 1);

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CFG_W       = 12;
    localparam int unsigned CNT_W       = 12;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned RUN_W       = 3;
    // offset of an output bit within the current input byte, 0 to 8
    localparam int unsigned OFS_W       = 4;

    localparam logic [CFG_W-1:0] MAX_FRAME_RESET = CFG_W'(256);

    // ones before a stuffed zero, and bit position a valid flag ends on
    localparam logic [RUN_W-1:0] STUFF_RUN = RUN_W'(5);
    localparam logic [2:0]       FLAG_POS  = 3'd6;

    // results queue depth and the room one request can need
    localparam int unsigned FIFO_DEPTH   = 4;
    localparam int unsigned FIFO_AW      = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW      = $clog2(FIFO_DEPTH + 1);
    localparam int unsigned MAX_RESULTS  = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_MISALIGNED = 2'd1,
        ST_OVERFLOW   = 2'd2,
        ST_NO_END     = 2'd3
    } t_status;

    typedef enum logic {
        KIND_DATA   = 1'b0,
        KIND_STATUS = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [BYTE_W-1:0]  data;
        t_status            status;
        logic [CNT_W-1:0]   count;
        logic               last;
    } t_result;

    // results of one input request handed from the decoder to the queue
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

// ----- sv/hbd_in_if.sv -----
// input channel of the decoder: one stuffed line byte per request
// depends on hbd_pkg for field widths
interface hbd_in_if;
    logic                       valid;
    logic                       ready;
    logic [hbd_pkg::BYTE_W-1:0] stuffed_byte;
    logic                       final_byte;

    modport source (output valid, output stuffed_byte, output final_byte, input ready);
    modport sink   (input valid, input stuffed_byte, input final_byte, output ready);
endinterface

// ----- sv/hbd_out_if.sv -----
// result channel of the decoder: data bytes and frame end status
// depends on hbd_pkg for field widths
interface hbd_out_if;
    logic                         valid;
    logic                         ready;
    logic                         result_kind;
    logic [hbd_pkg::BYTE_W-1:0]   data_byte;
    logic [hbd_pkg::STATUS_W-1:0] end_status;
    logic [hbd_pkg::CNT_W-1:0]    frame_bytes;
    logic                         run_last;

    modport source (output valid, output result_kind, output data_byte,
                    output end_status, output frame_bytes, output run_last,
                    input ready);
    modport sink   (input valid, input result_kind, input data_byte,
                    input end_status, input frame_bytes, input run_last,
                    output ready);
endinterface

// ----- sv/hbd_core.sv -----
// input register, frame state and the unrolled eight bit destuffing decision
// depends on hbd_pkg; feeds hbd_res_fifo with up to two results per request
module hbd_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [hbd_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [hbd_pkg::BYTE_W-1:0]  i_stuffed_byte,
    input  logic                        i_final_byte,
    input  logic                        i_room,
    output hbd_pkg::t_push              o_push
);
    import hbd_pkg::*;

    logic [CFG_W-1:0]  r_max_frame;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_final;
    logic [RUN_W-1:0]  r_ones_run;
    logic              r_drop;
    logic [POS_W-1:0]  r_pos;
    logic [BYTE_W-1:0] r_partial;

    logic [RUN_W-1:0]  n_ones_run;
    logic              n_drop;
    logic [POS_W-1:0]  n_pos;
    logic [BYTE_W-1:0] n_partial;

    logic              advance;
    logic              accept;
    logic [CFG_W-1:0]  limit;
    logic [POS_W-1:0]  limit_bits;
    logic [POS_W-1:0]  lim_diff;
    logic [POS_W-1:0]  max_diff;
    logic [OFS_W-1:0]  head_lim;
    logic [OFS_W-1:0]  head_max;
    logic [POS_W-1:0]  pos_now;

    logic              ended;
    t_status           status;
    logic              byte_emit;
    logic [BYTE_W-1:0] byte_data;
    logic [OFS_W-1:0]  ofs;
    logic [RUN_W-1:0]  run;
    logic              drop;
    logic [BYTE_W-1:0] part;
    logic              flag_seen;
    t_result           res_data;
    t_result           res_stat;

    assign advance = r_in_valid && i_room;
    assign o_ready = !r_in_valid || i_room;
    assign accept  = i_valid && o_ready;

    // limit in force and how far ahead of the current position it lies
    assign limit      = (r_max_frame > CFG_W'(FRAME_LIMIT)) ? CFG_W'(FRAME_LIMIT) : r_max_frame;
    assign limit_bits = POS_W'({limit, 3'b000});
    assign lim_diff   = (limit_bits > r_pos) ? (limit_bits - r_pos) : '0;
    assign max_diff   = POS_W'(POS_MAX) - r_pos;
    assign head_lim   = (lim_diff > POS_W'(9)) ? OFS_W'(9) : OFS_W'(lim_diff);
    assign head_max   = (max_diff > POS_W'(9)) ? OFS_W'(9) : OFS_W'(max_diff);

    // eight dependent bit steps; positions tracked as a small offset
    always_comb begin
        logic       adv;
        logic [2:0] low;
        ended     = 1'b0;
        status    = ST_OK;
        byte_emit = 1'b0;
        byte_data = '0;
        ofs       = '0;
        run       = r_ones_run;
        drop      = r_drop;
        part      = r_partial;
        flag_seen = 1'b0;
        adv       = 1'b0;
        low       = '0;
        for (int i = 0; i < BYTE_W; i++) begin
            adv = 1'b0;
            low = r_pos[2:0] + ofs[2:0];
            if (!ended) begin
                if (r_in_byte[i]) begin
                    if (drop) begin
                        ended     = 1'b1;
                        flag_seen = 1'b1;
                        status    = (low == FLAG_POS) ? ST_OK : ST_MISALIGNED;
                    end else if (ofs >= head_lim) begin
                        ended  = 1'b1;
                        status = ST_OVERFLOW;
                    end else begin
                        part[low] = 1'b1;
                        if (run == STUFF_RUN - RUN_W'(1)) begin
                            drop = 1'b1;
                            run  = '0;
                        end else begin
                            run = run + RUN_W'(1);
                        end
                        adv = 1'b1;
                    end
                end else begin
                    run = '0;
                    if (drop) begin
                        drop = 1'b0;
                    end else begin
                        adv = 1'b1;
                    end
                end
                if (adv && (ofs < head_max)) begin
                    ofs = ofs + OFS_W'(1);
                    low = r_pos[2:0] + ofs[2:0];
                    if (low == 3'd0) begin
                        if (ofs <= head_lim) begin
                            byte_emit = 1'b1;
                            byte_data = part;
                        end
                        part = '0;
                    end
                end
            end
        end
        if (!ended && r_in_final) begin
            ended  = 1'b1;
            status = ST_NO_END;
        end
    end

    assign pos_now = r_pos + POS_W'(ofs);

    always_comb begin
        res_data.kind   = KIND_DATA;
        res_data.data   = byte_data;
        res_data.status = ST_OK;
        res_data.count  = '0;
        res_data.last   = !ended;

        res_stat.kind   = KIND_STATUS;
        res_stat.data   = '0;
        res_stat.status = status;
        res_stat.count  = (flag_seen && (status == ST_OK)) ? CNT_W'(pos_now >> 3) : '0;
        res_stat.last   = 1'b1;

        o_push.res1 = res_stat;
        if (byte_emit) begin
            o_push.res0 = res_data;
        end else begin
            o_push.res0 = res_stat;
        end
        if (!advance) begin
            o_push.cnt = 2'd0;
        end else begin
            o_push.cnt = 2'(byte_emit) + 2'(ended);
        end
    end

    always_comb begin
        if (ended) begin
            n_ones_run = '0;
            n_drop     = 1'b0;
            n_pos      = '0;
            n_partial  = '0;
        end else begin
            n_ones_run = run;
            n_drop     = drop;
            n_pos      = pos_now;
            n_partial  = part;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frame <= MAX_FRAME_RESET;
            r_in_valid  <= 1'b0;
            r_ones_run  <= '0;
            r_drop      <= 1'b0;
            r_pos       <= '0;
            r_partial   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_max_frame <= i_cfg_wdata;
            end
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_ones_run <= n_ones_run;
                r_drop     <= n_drop;
                r_pos      <= n_pos;
                r_partial  <= n_partial;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte  <= i_stuffed_byte;
            r_in_final <= i_final_byte;
        end
    end

endmodule

// ----- sv/hbd_res_fifo.sv -----
// small queue: takes up to two results a cycle, hands one out on ready
// depends on hbd_pkg for the result and push types
module hbd_res_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hbd_pkg::t_push      i_push,
    output logic                o_room,
    output logic                o_valid,
    input  logic                i_ready,
    output hbd_pkg::t_result    o_res
);
    import hbd_pkg::*;

    t_result            r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [FIFO_CW-1:0] r_cnt;
    logic               pop;
    logic [FIFO_AW-1:0] wr_next;

    assign o_room  = r_cnt <= FIFO_CW'(FIFO_DEPTH - MAX_RESULTS);
    assign o_valid = r_cnt != '0;
    assign o_res   = r_mem[r_rd];
    assign pop     = o_valid && i_ready;
    assign wr_next = r_wr + FIFO_AW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + FIFO_AW'(i_push.cnt);
            r_cnt <= r_cnt + FIFO_CW'(i_push.cnt) - FIFO_CW'(pop);
            if (pop) begin
                r_rd <= r_rd + FIFO_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_next] <= i_push.res1;
        end
    end

endmodule

// ----- sv/hdlc_bit_destuffing_decoder.sv -----
// top level of the hdlc bit destuffing decoder
// depends on hbd_pkg, hbd_in_if, hbd_out_if, hbd_core and hbd_res_fifo
//
// Rebuilds frame bytes from the stuffed line bits that follow an opening
// flag. Each input request carries eight line bits, bit 0 first, plus a
// final_byte mark for the end of the received buffer. After five data ones
// the next zero is dropped as a stuffing bit; a sixth one is the closing
// flag, which is ok only when the output bit position mod 8 is 6 (then
// frame_bytes gives the whole bytes decoded), otherwise misaligned. A data
// one at or past max_frame_bytes gives overflow, and bytes completed past
// the limit are not sent. A buffer that ends without a flag gives no end
// flag. Any status clears the frame state and drops the rest of that input
// byte. Each request yields zero, one or two results (a data byte, then
// possibly a status); run_last marks the last one of the request.
// Timing: one request is taken per cycle; the eight bit decisions are
// combinational between the input register and a four entry results queue,
// so the first result of a request passes the input register and then the
// results queue before it is on the result channel. Input stalls only while
// the queue lacks room for two results, so the sustained rate is bounded by
// the result side taking one result per cycle. max_frame_bytes resets to 256
// and is written through i_cfg_we / i_cfg_wdata; the user must write it only
// while the block is idle, which the block itself does not enforce.
module hdlc_bit_destuffing_decoder (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [hbd_pkg::CFG_W-1:0] i_cfg_wdata,
    hbd_in_if.sink                    i_in,
    hbd_out_if.source                 o_res
);
    import hbd_pkg::*;

    t_push   push;
    t_result head;
    logic    room;

    // input register, frame state and bit decisions
    hbd_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_in.valid),
        .o_ready        (i_in.ready),
        .i_stuffed_byte (i_in.stuffed_byte),
        .i_final_byte   (i_in.final_byte),
        .i_room         (room),
        .o_push         (push)
    );

    // results wait here so the input side keeps moving under output stalls
    hbd_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_res   (head)
    );

    // unpack the queue head onto the result channel
    assign o_res.result_kind = head.kind;
    assign o_res.data_byte   = head.data;
    assign o_res.end_status  = head.status;
    assign o_res.frame_bytes = head.count;
    assign o_res.run_last    = head.last;

endmodule

// ----- tb/hdlc_bit_destuffing_decoder_tb.sv -----
`timescale 1ns / 100ps
// self-checking testbench for hdlc_bit_destuffing_decoder: directed and random line bytes,
// results predicted by a scoreboard class and checked in order, field by field
// depends on hbd_pkg, hbd_in_if, hbd_out_if and the decoder rtl

module hdlc_bit_destuffing_decoder_tb;
    import hbd_pkg::*;

    // cycles to let the block settle once nothing is pending
    localparam int unsigned DRAIN_CYCLES   = 12;
    localparam int unsigned DRAIN_GUARD    = 100000;
    // random requests per idling phase, four phases
    localparam int unsigned PHASE_REQUESTS = 350;
    // long frame that lands one byte short of its limit, count past eight bits
    localparam int unsigned LONG_FRAME     = 300;

    // predicts the results of each accepted request and checks them in arrival order
    class frame_scoreboard;
        logic [CFG_W-1:0]  max_frame_bytes;
        logic [RUN_W-1:0]  ones_run;
        logic              stuff_zero_due;
        logic [POS_W-1:0]  out_pos;
        logic [BYTE_W-1:0] byte_acc;
        t_result           request_q[$];
        t_result           expected_q[$];
        int                errors;
        int                n_results;
        int                n_status[4];

        function new();
            max_frame_bytes = MAX_FRAME_RESET;
            clear_frame();
            errors = 0;
            n_results = 0;
            foreach (n_status[k])
                n_status[k] = 0;
        endfunction

        function void clear_frame();
            ones_run = '0;
            stuff_zero_due = 1'b0;
            out_pos = '0;
            byte_acc = '0;
        endfunction

        function void set_limit(logic [CFG_W-1:0] v);
            max_frame_bytes = v;
        endfunction

        function t_result make_result(t_kind k, logic [BYTE_W-1:0] d, t_status s,
                                      logic [CNT_W-1:0] c);
            t_result r;
            r.kind = k;
            r.data = d;
            r.status = s;
            r.count = c;
            r.last = 1'b0;
            return r;
        endfunction

        function void add_status(t_status s, logic [CNT_W-1:0] c);
            request_q.push_back(make_result(KIND_STATUS, '0, s, c));
            n_status[int'(s)]++;
        endfunction

        // one output bit placed; a byte that fills inside the limit goes out
        function void advance_pos(logic [15:0] lim_bits);
            if (out_pos >= POS_W'(POS_MAX))
                return;
            out_pos++;
            if (out_pos[2:0] == 3'd0) begin
                if ({1'b0, out_pos} <= lim_bits)
                    request_q.push_back(make_result(KIND_DATA, byte_acc, ST_OK, '0));
                byte_acc = '0;
            end
        endfunction

        function void note_request(logic [BYTE_W-1:0] line, logic fin);
            logic [CFG_W-1:0] lim;
            logic [15:0]      lim_bits;
            bit               ended;
            int               i;
            ended = 1'b0;
            request_q.delete();
            lim = (max_frame_bytes > FRAME_LIMIT) ? CFG_W'(FRAME_LIMIT) : max_frame_bytes;
            lim_bits = {1'b0, lim, 3'b000};
            for (i = 0; i < 8 && !ended; i++) begin
                if (line[i]) begin
                    if (stuff_zero_due) begin
                        // sixth one in a row: closing flag
                        if (out_pos[2:0] == FLAG_POS)
                            add_status(ST_OK, out_pos[POS_W-1:3]);
                        else
                            add_status(ST_MISALIGNED, '0);
                        ended = 1'b1;
                    end else if (out_pos >= lim_bits) begin
                        add_status(ST_OVERFLOW, '0);
                        ended = 1'b1;
                    end else begin
                        byte_acc[out_pos[2:0]] = 1'b1;
                        ones_run++;
                        if (ones_run >= STUFF_RUN) begin
                            stuff_zero_due = 1'b1;
                            ones_run = '0;
                        end
                        advance_pos(lim_bits);
                    end
                end else begin
                    ones_run = '0;
                    if (stuff_zero_due)
                        stuff_zero_due = 1'b0;
                    else
                        advance_pos(lim_bits);
                end
            end
            if (!ended && fin) begin
                add_status(ST_NO_END, '0);
                ended = 1'b1;
            end
            if (ended)
                clear_frame();
            if (request_q.size() != 0)
                request_q[request_q.size() - 1].last = 1'b1;
            foreach (request_q[k])
                expected_q.push_back(request_q[k]);
        endfunction

        function bit field_differs(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void check_result(t_result got);
            t_result want;
            bit      bad;
            if (expected_q.size() == 0) begin
                $display("%0t: result with nothing expected: kind %0d data %02h status %0d count %0d",
                         $time, got.kind, got.data, got.status, got.count);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            n_results++;
            bad = 1'b0;
            bad |= field_differs("result_kind", CNT_W'(want.kind), CNT_W'(got.kind));
            bad |= field_differs("data_byte", CNT_W'(want.data), CNT_W'(got.data));
            bad |= field_differs("end_status", CNT_W'(want.status), CNT_W'(got.status));
            bad |= field_differs("frame_bytes", want.count, got.count);
            bad |= field_differs("run_last", CNT_W'(want.last), CNT_W'(got.last));
            if (bad)
                errors++;
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CFG_W-1:0]   i_cfg_wdata;

    hbd_in_if  in_ch();
    hbd_out_if res_ch();

    frame_scoreboard sb;

    // idling knobs, changed per phase
    int unsigned sender_idle_pct;
    int unsigned stall_pct;
    int unsigned cur_limit;
    int          n_sent;
    int          n_limits;

    // line bits waiting to be packed into requests, and the ones run for stuffing
    bit line_q[$];
    int line_ones;

    hdlc_bit_destuffing_decoder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_res       (res_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver side: ready drops at random by the current stall percentage
    always @(posedge i_clk) begin
        res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // every accepted request goes to the predictor
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
            sb.note_request(in_ch.stuffed_byte, in_ch.final_byte);
    end

    // every accepted result is checked against the oldest prediction
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            got.kind = t_kind'(res_ch.result_kind);
            got.data = res_ch.data_byte;
            got.status = t_status'(res_ch.end_status);
            got.count = res_ch.frame_bytes;
            got.last = res_ch.run_last;
            sb.check_result(got);
        end
    end

    // one request; may idle first, then holds valid until the handshake
    task automatic send(input logic [BYTE_W-1:0] b, input logic fin);
        if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
            in_ch.valid <= 1'b0;
            do
                @(posedge i_clk);
            while ($urandom_range(0, 99) < sender_idle_pct);
        end
        in_ch.valid <= 1'b1;
        in_ch.stuffed_byte <= b;
        in_ch.final_byte <= fin;
        do
            @(posedge i_clk);
        while (in_ch.ready !== 1'b1);
        n_sent++;
    endtask

    // drop valid, wait for every predicted result, then let the pipe settle
    task automatic wait_drained();
        int guard;
        guard = 0;
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // register write only with the block idle
    task automatic write_limit(input int unsigned v);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= CFG_W'(v);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_limit(CFG_W'(v));
        cur_limit = v;
        n_limits++;
    endtask

    // frame content biased toward long runs of ones so stuffing shows up often
    function automatic logic [BYTE_W-1:0] pick_data();
        case ($urandom_range(0, 5))
            0: return 8'hFF;
            1: return 8'h7E;
            2: return 8'hF8 | 8'($urandom_range(0, 7));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // data byte onto the line, lsb first, with a zero after every five ones
    function automatic void push_data(input logic [BYTE_W-1:0] d);
        int i;
        for (i = 0; i < 8; i++) begin
            line_q.push_back(d[i]);
            if (d[i]) begin
                line_ones++;
                if (line_ones == 5) begin
                    line_q.push_back(1'b0);
                    line_ones = 0;
                end
            end else begin
                line_ones = 0;
            end
        end
    endfunction

    function automatic void queue_frame(input int n_bytes);
        repeat (n_bytes) push_data(pick_data());
    endfunction

    // closing flag 01111110, sent unstuffed
    function automatic void push_flag();
        line_q.push_back(1'b0);
        repeat (6) line_q.push_back(1'b1);
        line_q.push_back(1'b0);
        line_ones = 0;
    endfunction

    // pad the line to whole bytes with random bits and send it
    task automatic flush_line(input bit fin);
        logic [BYTE_W-1:0] b;
        int                nb;
        int                j;
        int                k;
        while (line_q.size() % 8 != 0)
            line_q.push_back(1'($urandom_range(0, 1)));
        nb = line_q.size() / 8;
        for (j = 0; j < nb; j++) begin
            for (k = 0; k < 8; k++)
                b[k] = line_q[8 * j + k];
            send(b, fin && (j == nb - 1));
        end
        line_q.delete();
        line_ones = 0;
    endtask

    // mostly well-formed frames; the rest misaligned, cut short, too long or noise
    task automatic random_traffic(input int n_requests);
        int start;
        int pick;
        int n_bytes;
        start = n_sent;
        while (n_sent - start < n_requests) begin
            pick = $urandom_range(0, 99);
            n_bytes = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
            if (pick < 55) begin
                queue_frame(n_bytes);
                push_flag();
                flush_line(1'($urandom_range(0, 1)));
            end else if (pick < 67) begin
                // stray zeros before the flag shift it off the byte grid
                queue_frame(n_bytes);
                repeat ($urandom_range(1, 7)) line_q.push_back(1'b0);
                line_ones = 0;
                push_flag();
                flush_line(1'($urandom_range(0, 1)));
            end else if (pick < 77) begin
                // buffer ends without a flag
                queue_frame((n_bytes == 0) ? 1 : n_bytes);
                flush_line(1'b1);
            end else if (pick < 87) begin
                // runs past the limit when the limit is small
                if (cur_limit <= 48)
                    n_bytes = cur_limit + $urandom_range(0, 3);
                queue_frame(n_bytes);
                push_flag();
                flush_line(1'($urandom_range(0, 1)));
            end else begin
                repeat ($urandom_range(1, 4))
                    send(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
        end
    endtask

    initial begin
        int ph;
        sb = new();
        n_sent = 0;
        n_limits = 0;
        sender_idle_pct = 0;
        stall_pct = 0;
        cur_limit = int'(MAX_FRAME_RESET);
        line_ones = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= '0;
        in_ch.valid <= 1'b0;
        in_ch.stuffed_byte <= '0;
        in_ch.final_byte <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset limit of 256 bytes
        send(8'h7E, 1'b0);              // empty frame, flag right away
        send(8'h00, 1'b0);              // one zero byte then the flag
        send(8'h7E, 1'b0);
        push_data(8'hFF);               // stuffed zero inside a byte of all ones
        push_data(8'h7E);
        push_flag();
        flush_line(1'b0);
        send(8'h3F, 1'b0);              // six ones at bit 5: misaligned flag
        send(8'h00, 1'b1);              // data byte then missing flag, two results
        send(8'h7E, 1'b1);              // final mark on the flag byte itself
        send(8'hFF, 1'b1);              // flag wins over the final mark
        send(8'hAA, 1'b0);
        send(8'h55, 1'b1);

        // one byte limit: zeros past the limit drop bytes, a one overflows
        write_limit(1);
        send(8'h01, 1'b0);
        send(8'h01, 1'b0);
        send(8'h00, 1'b0);
        send(8'h00, 1'b0);
        send(8'h80, 1'b0);

        // zero limit: any data one overflows
        write_limit(0);
        send(8'h00, 1'b0);
        send(8'h01, 1'b1);
        send(8'h7E, 1'b0);

        // frame one byte short of its limit, count wider than eight bits
        write_limit(LONG_FRAME + 1);
        queue_frame(LONG_FRAME);
        push_flag();
        flush_line(1'b1);

        // random phases: no idling, sender idle, receiver stalls, both
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_limit(FRAME_LIMIT);
                1: write_limit($urandom_range(2, 24));
                2: write_limit(1);
                default: write_limit($urandom_range(25, 300));
            endcase
            sender_idle_pct = (ph == 1) ? 80 : (ph == 3) ? 38 : 0;
            stall_pct = (ph == 2) ? 80 : (ph == 3) ? 38 : 0;
            random_traffic(PHASE_REQUESTS);
        end

        wait_drained();
        if (sb.expected_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.expected_q.size());
            sb.errors++;
        end
        $display("%0d line bytes sent under %0d limit settings, %0d results checked",
                 n_sent, n_limits + 1, sb.n_results);
        $display("frame ends: ok %0d, misaligned %0d, overflow %0d, no flag %0d",
                 sb.n_status[ST_OK], sb.n_status[ST_MISALIGNED],
                 sb.n_status[ST_OVERFLOW], sb.n_status[ST_NO_END]);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/hbd_pkg.sv
sv/hbd_in_if.sv
sv/hbd_out_if.sv
sv/hbd_core.sv
sv/hbd_res_fifo.sv
sv/hdlc_bit_destuffing_decoder.sv
tb/hdlc_bit_destuffing_decoder_tb.sv
